// ===== hw/rtl/sfr_pkg.sv =====
// Shared types and constants of the stream find-and-replace block.
package sfr_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 4;
   localparam int TALLY_W = 16;
   localparam int OLEN_W  = 33;
   localparam int DATA_W  = 64;
   localparam int ADDR_W  = 6;
   localparam int SIZE_W  = 32;

   typedef enum logic [2:0] {
      REG_FIND_PATTERN    = 3'd0,
      REG_FIND_LENGTH     = 3'd1,
      REG_REPLACE_PATTERN = 3'd2,
      REG_REPLACE_LENGTH  = 3'd3,
      REG_BUFFER_SIZE     = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPL,
      ST_FLUSH,
      ST_CLOSE
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] find_pattern;
      logic [LEN_W-1:0]  find_length;
      logic [DATA_W-1:0] replace_pattern;
      logic [LEN_W-1:0]  replace_length;
      logic [SIZE_W-1:0] buffer_size;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/sfr_if.sv =====
// Stream interfaces for the input and result channels.
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last_in;

   modport source (output valid, output char_in, output last_in, input ready);
   modport sink (input valid, input char_in, input last_in, output ready);
endinterface

interface sfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  char_out;
   logic        char_valid;
   logic        last_out;
   logic [15:0] occurrence_count;
   logic        overflow;

   modport source (output valid, output char_out, output char_valid, output last_out,
                   output occurrence_count, output overflow, input ready);
   modport sink (input valid, input char_out, input char_valid, input last_out,
                 input occurrence_count, input overflow, output ready);
endinterface

// ===== hw/rtl/sfr_cell.sv =====
// One window cell: holds a text byte, compares it with its pattern byte.
module sfr_cell
   import sfr_pkg::*;
(
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [BYTE_W-1:0] char_in,
   input  logic [BYTE_W-1:0] next_byte,
   input  logic [BYTE_W-1:0] pat_byte,
   output logic [BYTE_W-1:0] byte_out,
   output logic              hit
);

   logic [BYTE_W-1:0] byte_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         byte_ff <= char_in;
      end else if (ctl.shift) begin
         byte_ff <= next_byte;
      end
   end

   assign byte_out = byte_ff;
   assign hit      = (byte_ff == pat_byte);

endmodule

// ===== hw/rtl/sfr_csr.sv =====
// Configuration registers behind the APB-style port.
module sfr_csr
   import sfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type idx;

   assign idx    = reg_index_type'(paddr[5:3]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.find_pattern    <= '0;
         cfg_ff.find_length     <= '0;
         cfg_ff.replace_pattern <= '0;
         cfg_ff.replace_length  <= '0;
         cfg_ff.buffer_size     <= '1;
      end else if (wr_en) begin
         case (idx)
            REG_FIND_PATTERN:    cfg_ff.find_pattern    <= pwdata;
            REG_FIND_LENGTH:     cfg_ff.find_length     <= pwdata[LEN_W-1:0];
            REG_REPLACE_PATTERN: cfg_ff.replace_pattern <= pwdata;
            REG_REPLACE_LENGTH:  cfg_ff.replace_length  <= pwdata[LEN_W-1:0];
            REG_BUFFER_SIZE:     cfg_ff.buffer_size     <= pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_FIND_PATTERN:    prdata = cfg_ff.find_pattern;
         REG_FIND_LENGTH:     prdata = DATA_W'(cfg_ff.find_length);
         REG_REPLACE_PATTERN: prdata = cfg_ff.replace_pattern;
         REG_REPLACE_LENGTH:  prdata = DATA_W'(cfg_ff.replace_length);
         REG_BUFFER_SIZE:     prdata = DATA_W'(cfg_ff.buffer_size);
         default:             prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/stream_find_replace_top.sv =====
// Top level of the stream find-and-replace block.
//
// Text bytes enter on req_chan (valid/ready), one beat per byte, last_in
// marking the final byte of a text. Rewritten bytes leave on rsp_chan, one
// beat per byte; the final beat of a text carries last_out, the saturating
// replacement count and the overflow flag (an empty beat with char_valid low
// if the final byte released nothing). Registers are written through the
// APB-style port at byte address 8*i; the user is to write them only while
// the block is idle, which the block itself does not enforce. A byte is
// accepted, then checked against the find pattern in the cell row; bytes
// released from the window and replacement bytes then leave one at a time,
// and the closing beat follows. Only one byte is in work at a time; the
// window sits in a row of MAX_FIND cells that shift toward cell zero as
// bytes are released.
// Reset empties the window, clears the counters and restores the register
// defaults. When the receiver stalls, the output register holds its beat
// and the block waits at the next byte it has to emit.
module stream_find_replace_top
   import sfr_pkg::*;
#(
   parameter int MAX_FIND    = 8,
   parameter int MAX_REPLACE = 8
) (
   input  logic              clock,
   input  logic              reset,
   sfr_req_if.sink           req_chan,
   sfr_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int FILL_W = $clog2(MAX_FIND + 1);

   cfg_type cfg;

   state_type            state_ff, state_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 tail_ff, tail_in;
   logic [LEN_W-1:0]     rcnt_ff, rcnt_in;
   logic [TALLY_W-1:0]   tally_ff, tally_in;
   logic [OLEN_W-1:0]    olen_ff, olen_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [BYTE_W-1:0]    pend_byte_ff, pend_byte_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [BYTE_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_cv_ff, rsp_cv_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [TALLY_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic [BYTE_W-1:0]    cell_byte [MAX_FIND];
   logic [MAX_FIND-1:0]  cell_hit;
   logic [MAX_FIND-1:0]  cell_ok;
   logic                 do_load, do_shift;
   logic                 prefix;
   logic [LEN_W-1:0]     flen, rlen;
   logic                 out_free, can_emit, emit;
   logic [BYTE_W-1:0]    emit_byte;

   sfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign flen = (cfg.find_length > LEN_W'(MAX_FIND)) ? LEN_W'(MAX_FIND) : cfg.find_length;
   assign rlen = (cfg.replace_length > LEN_W'(MAX_REPLACE)) ?
                 LEN_W'(MAX_REPLACE) : cfg.replace_length;

   for (genvar i = 0; i < MAX_FIND; i++) begin : g_cell
      cell_ctl_type      ctl;
      logic [BYTE_W-1:0] nxt;

      assign ctl.load  = do_load && (fill_ff == FILL_W'(i));
      assign ctl.shift = do_shift;
      if (i < MAX_FIND - 1) begin : g_mid
         assign nxt = cell_byte[i+1];
      end else begin : g_end
         assign nxt = cell_byte[i];
      end
      assign cell_ok[i] = (FILL_W'(i) >= fill_ff) || cell_hit[i];

      sfr_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .char_in   (req_chan.char_in),
         .next_byte (nxt),
         .pat_byte  (cfg.find_pattern[i*BYTE_W +: BYTE_W]),
         .byte_out  (cell_byte[i]),
         .hit       (cell_hit[i])
      );
   end

   assign prefix   = (&cell_ok) && (LEN_W'(fill_ff) <= flen);
   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign can_emit = tail_ff ? (!pend_vld_ff || out_free) : out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         tail_ff     <= 1'b0;
         rcnt_ff     <= '0;
         tally_ff    <= '0;
         olen_ff     <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         tail_ff     <= tail_in;
         rcnt_ff     <= rcnt_in;
         tally_ff    <= tally_in;
         olen_ff     <= olen_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_cv_ff    <= rsp_cv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      tail_in      = tail_ff;
      rcnt_in      = rcnt_ff;
      tally_in     = tally_ff;
      olen_in      = olen_ff;
      pend_vld_in  = pend_vld_ff;
      pend_byte_in = pend_byte_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_chan.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      req_chan.ready = 1'b0;
      do_load   = 1'b0;
      do_shift  = 1'b0;
      emit      = 1'b0;
      emit_byte = cell_byte[0];

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               do_load  = 1'b1;
               fill_in  = fill_ff + 1'b1;
               tail_in  = req_chan.last_in;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((fill_ff != '0) && !prefix) begin
               if (can_emit) begin
                  emit     = 1'b1;
                  do_shift = 1'b1;
                  fill_in  = fill_ff - 1'b1;
               end
            end else if ((flen != '0) && (LEN_W'(fill_ff) == flen)) begin
               fill_in = '0;
               if (tally_ff != '1) begin
                  tally_in = tally_ff + 1'b1;
               end
               if (rlen != '0) begin
                  rcnt_in  = '0;
                  state_in = ST_REPL;
               end else begin
                  state_in = tail_ff ? ST_CLOSE : ST_IDLE;
               end
            end else begin
               state_in = tail_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_REPL: begin
            emit_byte = cfg.replace_pattern[{rcnt_ff[2:0], 3'b000} +: BYTE_W];
            if (can_emit) begin
               emit    = 1'b1;
               rcnt_in = rcnt_ff + 1'b1;
               if ((rcnt_ff + 4'd1) == rlen) begin
                  state_in = tail_ff ? ST_CLOSE : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (fill_ff != '0) begin
               if (can_emit) begin
                  emit     = 1'b1;
                  do_shift = 1'b1;
                  fill_in  = fill_ff - 1'b1;
               end
            end else begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_char_in  = pend_vld_ff ? pend_byte_ff : '0;
               rsp_cv_in    = pend_vld_ff;
               rsp_last_in  = 1'b1;
               rsp_count_in = tally_ff;
               rsp_ovf_in   = olen_ff > OLEN_W'(cfg.buffer_size);
               tally_in     = '0;
               olen_in      = '0;
               pend_vld_in  = 1'b0;
               tail_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // In the final text byte's work one beat is held back so that the
      // closing beat can carry the last emitted byte.
      if (emit) begin
         if (olen_ff != '1) begin
            olen_in = olen_ff + 1'b1;
         end
         if (tail_ff) begin
            pend_vld_in  = 1'b1;
            pend_byte_in = emit_byte;
         end
         if (!tail_ff || pend_vld_ff) begin
            rsp_vld_in   = 1'b1;
            rsp_char_in  = tail_ff ? pend_byte_ff : emit_byte;
            rsp_cv_in    = 1'b1;
            rsp_last_in  = 1'b0;
            rsp_count_in = '0;
            rsp_ovf_in   = 1'b0;
         end
      end
   end

   assign rsp_chan.valid            = rsp_vld_ff;
   assign rsp_chan.char_out         = rsp_char_ff;
   assign rsp_chan.char_valid       = rsp_cv_ff;
   assign rsp_chan.last_out         = rsp_last_ff;
   assign rsp_chan.occurrence_count = rsp_count_ff;
   assign rsp_chan.overflow         = rsp_ovf_ff;

endmodule

// ===== tb/sfr_tb_pkg.sv =====
// Result prediction and checking for the stream find-and-replace testbench.
package sfr_tb_pkg;
   import sfr_pkg::*;

   localparam int unsigned WINDOW_DEPTH  = 8;
   localparam int unsigned REPLACE_DEPTH = 8;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [BYTE_W-1:0]  char_out;
      logic               char_valid;
      logic               last_out;
      logic [TALLY_W-1:0] occurrence_count;
      logic               overflow;
   } rewrite_beat;

   class find_replace_scoreboard;
      bit [DATA_W-1:0]  find_pattern;
      bit [LEN_W-1:0]   find_length;
      bit [DATA_W-1:0]  replace_pattern;
      bit [LEN_W-1:0]   replace_length;
      bit [SIZE_W-1:0]  buffer_size;
      bit [BYTE_W-1:0]  held_bytes [WINDOW_DEPTH];
      int unsigned      held_count;
      bit [TALLY_W-1:0] replace_tally;
      bit [OLEN_W-1:0]  output_length;
      rewrite_beat      expected_beats[$];
      int unsigned      mismatches;
      int unsigned      beats_checked;
      int unsigned      texts_closed;

      function new();
         find_pattern    = '0;
         find_length     = '0;
         replace_pattern = '0;
         replace_length  = '0;
         buffer_size     = '1;
         held_count      = 0;
         replace_tally   = '0;
         output_length   = '0;
         mismatches      = 0;
         beats_checked   = 0;
         texts_closed    = 0;
      endfunction

      function int unsigned pending();
         return expected_beats.size();
      endfunction

      function void write_register(reg_index_type idx, bit [DATA_W-1:0] value);
         case (idx)
            REG_FIND_PATTERN:    find_pattern    = value;
            REG_FIND_LENGTH:     find_length     = value[LEN_W-1:0];
            REG_REPLACE_PATTERN: replace_pattern = value;
            REG_REPLACE_LENGTH:  replace_length  = value[LEN_W-1:0];
            REG_BUFFER_SIZE:     buffer_size     = value[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function void emit_byte(bit [BYTE_W-1:0] value);
         rewrite_beat beat;
         beat            = '0;
         beat.char_out   = value;
         beat.char_valid = 1'b1;
         expected_beats.push_back(beat);
         if (output_length != '1) output_length++;
      endfunction

      function bit window_on_pattern(int unsigned flen);
         if (held_count > flen) return 1'b0;
         for (int unsigned i = 0; i < held_count; i++) begin
            if (held_bytes[i] != find_pattern[i*8 +: 8]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void release_oldest();
         emit_byte(held_bytes[0]);
         for (int unsigned i = 1; i < held_count; i++) held_bytes[i-1] = held_bytes[i];
         held_count--;
      endfunction

      function void note_input(bit [BYTE_W-1:0] value, bit last);
         int unsigned flen;
         int unsigned rlen;
         int unsigned first;
         rewrite_beat closing;
         flen  = (find_length > WINDOW_DEPTH) ? WINDOW_DEPTH : find_length;
         rlen  = (replace_length > REPLACE_DEPTH) ? REPLACE_DEPTH : replace_length;
         first = expected_beats.size();
         if (held_count == WINDOW_DEPTH) release_oldest();
         held_bytes[held_count] = value;
         held_count++;
         while (held_count > 0 && !window_on_pattern(flen)) release_oldest();
         if (flen > 0 && held_count == flen) begin
            for (int unsigned i = 0; i < rlen; i++) emit_byte(replace_pattern[i*8 +: 8]);
            held_count = 0;
            if (replace_tally != '1) replace_tally++;
         end
         if (last) begin
            while (held_count > 0) release_oldest();
            if (expected_beats.size() == first) expected_beats.push_back('0);
            closing                  = expected_beats.pop_back();
            closing.last_out         = 1'b1;
            closing.occurrence_count = replace_tally;
            closing.overflow         = (output_length > {1'b0, buffer_size});
            expected_beats.push_back(closing);
            held_count    = 0;
            replace_tally = '0;
            output_length = '0;
            texts_closed++;
         end
      endfunction

      function void check_result(logic [BYTE_W-1:0] char_out, logic char_valid,
                                 logic last_out, logic [TALLY_W-1:0] occurrence_count,
                                 logic overflow);
         rewrite_beat want;
         beats_checked++;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Unexpected result beat: char %h valid %b last %b count %0d ovf %b",
                        char_out, char_valid, last_out, occurrence_count, overflow);
            return;
         end
         want = expected_beats.pop_front();
         if (char_out !== want.char_out || char_valid !== want.char_valid ||
             last_out !== want.last_out || occurrence_count !== want.occurrence_count ||
             overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Beat %0d mismatch: expected char %h valid %b last %b count %0d ovf %b",
                        beats_checked, want.char_out, want.char_valid, want.last_out,
                        want.occurrence_count, want.overflow);
               $display("               actual   char %h valid %b last %b count %0d ovf %b",
                        char_out, char_valid, last_out, occurrence_count, overflow);
            end
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_stream_find_replace_top.sv =====
// Self-checking testbench of the stream find-and-replace top level.
module tb_stream_find_replace_top
   import sfr_pkg::*;
   import sfr_tb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned STALL_LIMIT  = 5000;
   localparam int unsigned PHASE_ITEMS  = 20;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   sfr_req_if req_chan ();
   sfr_rsp_if rsp_chan ();

   find_replace_scoreboard sb = new();

   bit          steady = 1'b0;
   int unsigned holds_requested = 0;
   int unsigned holds_served = 0;
   int unsigned bytes_sent = 0;
   int unsigned config_writes = 0;
   int unsigned idle_cycles = 0;

   stream_find_replace_top #(
      .MAX_FIND    (8),
      .MAX_REPLACE (8)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #5 clock = ~clock;

   task automatic send_byte(input logic [BYTE_W-1:0] value, input bit last);
      while (!steady && $urandom_range(99) < 14) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.char_in <= value;
      req_chan.last_in <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_input(value, last);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(8 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.write_register(idx, value);
      config_writes++;
   endtask

   task automatic csr_release();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_setup(input logic [DATA_W-1:0] find_bytes,
                                input logic [LEN_W-1:0] find_len,
                                input logic [DATA_W-1:0] replace_bytes,
                                input logic [LEN_W-1:0] replace_len,
                                input logic [SIZE_W-1:0] size_limit);
      wait_drained();
      csr_write(REG_FIND_PATTERN, find_bytes);
      csr_write(REG_FIND_LENGTH, DATA_W'(find_len));
      csr_write(REG_REPLACE_PATTERN, replace_bytes);
      csr_write(REG_REPLACE_LENGTH, DATA_W'(replace_len));
      csr_write(REG_BUFFER_SIZE, DATA_W'(size_limit));
      csr_release();
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return LEN_W'($urandom_range(15, 9));
      if (r < 35) return LEN_W'($urandom_range(8, 5));
      return LEN_W'($urandom_range(4, 1));
   endfunction

   task automatic random_setup(input bit wide_replace);
      logic [DATA_W-1:0] find_bytes;
      logic [LEN_W-1:0]  replace_len;
      logic [SIZE_W-1:0] size_limit;
      logic [BYTE_W-1:0] sym_a;
      logic [BYTE_W-1:0] sym_b;
      int unsigned       r;
      sym_a = BYTE_W'($urandom);
      sym_b = BYTE_W'($urandom);
      for (int i = 0; i < 8; i++) begin
         r = $urandom_range(99);
         find_bytes[i*8 +: 8] = (r < 40) ? sym_a : (r < 80) ? sym_b : BYTE_W'($urandom);
      end
      replace_len = wide_replace ? LEN_W'(8) : pick_length();
      r = $urandom_range(99);
      if (r < 10) size_limit = '0;
      else if (r < 40) size_limit = SIZE_W'($urandom_range(16));
      else if (r < 50) size_limit = '1;
      else size_limit = $urandom;
      program_setup(find_bytes, pick_length(), {$urandom, $urandom}, replace_len, size_limit);
   endtask

   task automatic random_text(input int unsigned count, input bit close_at_end);
      logic [BYTE_W-1:0] burst[$];
      int unsigned       flen;
      int unsigned       r;
      bit                last;
      flen = (sb.find_length > WINDOW_DEPTH) ? WINDOW_DEPTH : sb.find_length;
      while (burst.size() < count) begin
         r = $urandom_range(99);
         if (r < 45 && flen > 0) begin
            for (int unsigned k = 0; k < flen; k++) burst.push_back(sb.find_pattern[k*8 +: 8]);
         end else if (r < 75) begin
            burst.push_back(sb.find_pattern[$urandom_range(7)*8 +: 8]);
         end else begin
            burst.push_back(BYTE_W'($urandom));
         end
      end
      foreach (burst[k]) begin
         last = ($urandom_range(99) < 12) || (close_at_end && k == burst.size() - 1);
         send_byte(burst[k], last);
      end
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served < holds_requested) begin
            holds_served++;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= 14);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_result(rsp_chan.char_out, rsp_chan.char_valid, rsp_chan.last_out,
                         rsp_chan.occurrence_count, rsp_chan.overflow);
   end

   always @(posedge clock) begin
      if (reset || psel || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                  idle_cycles, sb.pending());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.char_in = '0;
      req_chan.last_in = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the reset settings the text passes through unchanged.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // A partial match is released, then a full match is replaced and the window flushed.
      program_setup(64'h6261, 4'd2, 64'h5A5958, 4'd3, '1);
      send_byte("a", 1'b0);
      send_byte("a", 1'b0);
      send_byte("b", 1'b0);
      send_byte("a", 1'b1);

      // Deleted match on the final byte gives an empty closing beat; a zero size overflows.
      program_setup(64'h6261, 4'd2, 64'h0, 4'd0, '0);
      send_byte("a", 1'b0);
      send_byte("b", 1'b1);
      send_byte("q", 1'b1);

      // Oversized lengths are clipped to eight bytes; output exactly at the size limit.
      program_setup('1, 4'd15, 64'h0123456789ABCDEF, 4'd15, 32'd8);
      repeat (7) send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);

      // Shortening the pattern while bytes are held releases them as non-matching.
      program_setup(64'h64636261, 4'd4, 64'h21, 4'd1, '1);
      send_byte("a", 1'b0);
      send_byte("b", 1'b0);
      send_byte("c", 1'b0);
      wait_drained();
      csr_write(REG_FIND_LENGTH, 64'd1);
      csr_release();
      send_byte("a", 1'b1);

      random_setup(1'b0);
      random_text(PHASE_ITEMS, 1'b0);

      random_setup(1'b0);
      steady = 1'b1;
      random_text(PHASE_ITEMS, 1'b1);
      wait_drained();
      steady = 1'b0;

      random_setup(1'b1);
      holds_requested++;
      random_text(PHASE_ITEMS, 1'b0);

      random_setup(1'b0);
      random_text(PHASE_ITEMS, 1'b0);

      random_setup(1'b0);
      random_text(PHASE_ITEMS, 1'b1);

      wait_drained();
      $display("Sent %0d text bytes in %0d texts and checked %0d result beats.",
               bytes_sent, sb.texts_closed, sb.beats_checked);
      $display("Used %0d register writes over clipped, zero and full lengths, %0d long hold(s).",
               config_writes, holds_served);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatching beats, %0d expected beats never arrived",
                  sb.mismatches, sb.pending());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_if.sv
hw/rtl/sfr_cell.sv
hw/rtl/sfr_csr.sv
hw/rtl/stream_find_replace_top.sv
tb/sfr_tb_pkg.sv
tb/tb_stream_find_replace_top.sv
